>>> src/ppcn_pkg.sv
// shared types and constants for the pixel power chroma normaliser
`default_nettype none
package ppcn_pkg;
   localparam int CHAN_W    = 8;
   localparam int ORDER_W   = 4;
   localparam int QUOT_BITS = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } rsp_type;
endpackage
`default_nettype wire

>>> src/ppcn_power.sv
// pipelined power chain: one conditional multiply per channel in every stage after the first
`default_nettype none
module ppcn_power
   import ppcn_pkg::*;
#(
   parameter int MAX_ORDER = 8,
   parameter int PW        = 8 * MAX_ORDER
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [2:0][CHAN_W-1:0]       in_chan,
   input  wire logic [ORDER_W-1:0]           in_order,
   output logic                              out_valid,
   output logic [2:0][PW-1:0]                out_pow
);
   logic [2:0][PW-1:0]     p_ff [MAX_ORDER];
   logic [2:0][PW-1:0]     p_in [MAX_ORDER];
   logic [2:0][CHAN_W-1:0] c_ff [MAX_ORDER];
   logic [ORDER_W-1:0]     e_ff [MAX_ORDER];
   logic                   v_ff [MAX_ORDER];

   // first stage: the power of order one is the channel itself; later stages multiply while below the order
   always_comb begin
      logic [PW+CHAN_W-1:0] prod;
      prod = '0;
      for (int ch = 0; ch < 3; ch++) begin
         p_in[0][ch] = PW'(in_chan[ch]);
      end
      for (int k = 1; k < MAX_ORDER; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod = (PW+CHAN_W)'(p_ff[k-1][ch]) * (PW+CHAN_W)'(c_ff[k-1][ch]);
            p_in[k][ch] = (ORDER_W'(k) < e_ff[k-1]) ? prod[PW-1:0] : p_ff[k-1][ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_ORDER; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < MAX_ORDER; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
      c_ff[0] <= in_chan;
      e_ff[0] <= in_order;
      for (int k = 1; k < MAX_ORDER; k++) begin
         c_ff[k] <= c_ff[k-1];
         e_ff[k] <= e_ff[k-1];
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
         p_ff[k] <= p_in[k];
      end
   end

   assign out_valid = v_ff[MAX_ORDER-1];
   assign out_pow   = p_ff[MAX_ORDER-1];
endmodule
`default_nettype wire

>>> src/ppcn_divider.sv
// pipelined restoring division, one quotient bit per channel in every stage after stage zero
`default_nettype none
module ppcn_divider
   import ppcn_pkg::*;
#(
   parameter int PW = 64,
   parameter int SW = PW + 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [2:0][PW-1:0]          in_part,
   input  wire logic [SW-1:0]               in_sum,
   output logic                             out_valid,
   output logic [2:0][QUOT_BITS-1:0]        out_quot
);
   localparam int DW = SW + QUOT_BITS;
   localparam int NS = QUOT_BITS + 1;

   logic [2:0][DW-1:0]        r_ff [NS];
   logic [2:0][DW-1:0]        r_in [NS];
   logic [2:0][QUOT_BITS-1:0] q_ff [NS];
   logic [2:0][QUOT_BITS-1:0] q_in [NS];
   logic [SW-1:0]             s_ff [NS];
   logic                      z_ff [NS];
   logic                      v_ff [NS];

   // stage zero: dividend is 255 times the part; later stages subtract the shifted sum where it fits
   always_comb begin
      logic [DW-1:0] d;
      d = '0;
      for (int ch = 0; ch < 3; ch++) begin
         r_in[0][ch] = (DW'(in_part[ch]) << QUOT_BITS) - DW'(in_part[ch]);
         q_in[0][ch] = '0;
      end
      for (int s = 1; s < NS; s++) begin
         d = DW'(s_ff[s-1]) << (QUOT_BITS - s);
         for (int ch = 0; ch < 3; ch++) begin
            r_in[s][ch] = r_ff[s-1][ch];
            q_in[s][ch] = q_ff[s-1][ch];
            if (d <= r_ff[s-1][ch]) begin
               r_in[s][ch]                  = r_ff[s-1][ch] - d;
               q_in[s][ch][QUOT_BITS - s]   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
      s_ff[0] <= in_sum;
      z_ff[0] <= (in_sum == '0);
      for (int s = 1; s < NS; s++) begin
         s_ff[s] <= s_ff[s-1];
         z_ff[s] <= z_ff[s-1];
      end
      for (int s = 0; s < NS; s++) begin
         r_ff[s] <= r_in[s];
         q_ff[s] <= q_in[s];
      end
   end

   assign out_valid = v_ff[NS-1];
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         out_quot[ch] = z_ff[NS-1] ? '0 : q_ff[NS-1][ch];
      end
   end
endmodule
`default_nettype wire

>>> src/pixel_power_chroma_normalize_unit.sv
// top level of the pixel power chroma normaliser
`default_nettype none
// throughput: one request every cycle, busy is never raised
// latency is set by MAX_ORDER power stages, the sum stage, nine divide stages and the output
// results cannot be stalled, each shows for one cycle under rsp_valid
// synchronous reset clears all valid bits and sets the order to one
module pixel_power_chroma_normalize_unit
   import ppcn_pkg::*;
#(
   parameter int MAX_ORDER = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [ORDER_W-1:0] csr_data
);
   localparam int PW = CHAN_W * MAX_ORDER;
   localparam int SW = PW + 2;

   // order register, always writable
   logic [ORDER_W-1:0] order_ff;
   logic [ORDER_W-1:0] eff_order;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(1);
      end else if (csr_valid) begin
         order_ff <= csr_data;
      end
   end

   // zero acts as one, anything above the maximum is clamped
   always_comb begin
      if (order_ff == '0) begin
         eff_order = ORDER_W'(1);
      end else if (order_ff > ORDER_W'(MAX_ORDER)) begin
         eff_order = ORDER_W'(MAX_ORDER);
      end else begin
         eff_order = order_ff;
      end
   end

   // power stages
   logic [2:0][CHAN_W-1:0] chan;
   logic                   pow_valid;
   logic [2:0][PW-1:0]     pow;

   assign chan = {req_data.red_in, req_data.green_in, req_data.blue_in};

   ppcn_power #(.MAX_ORDER(MAX_ORDER), .PW(PW)) u_power (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_chan   (chan),
      .in_order  (eff_order),
      .out_valid (pow_valid),
      .out_pow   (pow)
   );

   // sum of the three powers
   logic               sum_valid_ff;
   logic [SW-1:0]      sum_ff;
   logic [2:0][PW-1:0] part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= pow_valid;
      end
      sum_ff  <= SW'(pow[0]) + SW'(pow[1]) + SW'(pow[2]);
      part_ff <= pow;
   end

   // share of each channel
   logic                      div_valid;
   logic [2:0][QUOT_BITS-1:0] quot;

   ppcn_divider #(.PW(PW), .SW(SW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_part   (part_ff),
      .in_sum    (sum_ff),
      .out_valid (div_valid),
      .out_quot  (quot)
   );

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_ff.red_out   <= quot[2];
      rsp_ff.green_out <= quot[1];
      rsp_ff.blue_out  <= quot[0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

>>> dv/pixel_power_chroma_normalize_unit_checker.sv
// checker that predicts and compares normalised pixels
`default_nettype none
module pixel_power_chroma_normalize_unit_checker
   import ppcn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire req_type            req_data,
   input  wire logic               rsp_valid,
   input  wire rsp_type            rsp_data,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [ORDER_W-1:0] csr_data,
   output int                      fail_count,
   output int                      pending_count
);
   localparam int TOP_ORDER = 8;

   logic [ORDER_W-1:0] order_reg;
   rsp_type            expect_mem [64];
   logic [5:0]         wr_idx;
   logic [5:0]         rd_idx;
   int                 held;

   function automatic logic [7:0] share(logic [63:0] part, logic [79:0] total);
      logic [87:0] target;
      logic [7:0]  q;
      logic [7:0]  trial;
      target = 88'(part) * 88'd255;
      q = '0;
      for (int b = 7; b >= 0; b--) begin
         trial = q | (8'd1 << b);
         if (88'(total) * 88'(trial) <= target) q = trial;
      end
      return q;
   endfunction

   function automatic rsp_type normalise(req_type px, logic [ORDER_W-1:0] ord);
      int          e;
      logic [63:0] pw[3];
      logic [7:0]  ch[3];
      logic [79:0] total;
      rsp_type     r;
      e = (ord == 0) ? 1 : (ord > TOP_ORDER ? TOP_ORDER : int'(ord));
      ch[0] = px.red_in;
      ch[1] = px.green_in;
      ch[2] = px.blue_in;
      total = '0;
      for (int k = 0; k < 3; k++) begin
         pw[k] = 64'd1;
         for (int i = 0; i < e; i++) pw[k] = pw[k] * 64'(ch[k]);
         total = total + 80'(pw[k]);
      end
      if (total == 0) r = '0;
      else begin
         r.red_out   = share(pw[0], total);
         r.green_out = share(pw[1], total);
         r.blue_out  = share(pw[2], total);
      end
      return r;
   endfunction

   assign pending_count = held;

   always @(posedge clock) begin
      rsp_type want;
      int      delta;
      delta = 0;
      if (reset) begin
         order_reg <= 4'd1;
         wr_idx <= '0;
         rd_idx <= '0;
         held <= 0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) order_reg <= csr_data;
         if (start && !busy) begin
            expect_mem[wr_idx] <= normalise(req_data, order_reg);
            wr_idx <= wr_idx + 6'd1;
            delta = delta + 1;
         end
         if (rsp_valid) begin
            if (held == 0) begin
               $display("%0t: unexpected pixel, expected none, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expect_mem[rd_idx];
               rd_idx <= rd_idx + 6'd1;
               delta = delta - 1;
               if (want.red_out !== rsp_data.red_out ||
                   want.green_out !== rsp_data.green_out ||
                   want.blue_out !== rsp_data.blue_out) begin
                  $display("%0t: pixel mismatch, expected %h, actual %h",
                           $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         held <= held + delta;
      end
   end
endmodule
`default_nettype wire

>>> dv/pixel_power_chroma_normalize_unit_tb.sv
// stimulus and verdict for the pixel power chroma normaliser
`default_nettype none
module pixel_power_chroma_normalize_unit_tb;
   import ppcn_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [ORDER_W-1:0] csr_data;
   int                 fail_count;
   int                 pending_count;
   int                 cycle_count = 0;

   pixel_power_chroma_normalize_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   pixel_power_chroma_normalize_unit_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog, counts every cycle of the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one request, held until taken, then start dropped unless burst goes on
   task automatic send_pixel(input req_type px, input bit keep);
      start <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (!keep) start <= 1'b0;
   endtask

   // wait for the pipeline to empty, then let it settle
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // order register is only touched while idle
   task automatic write_order(input logic [ORDER_W-1:0] ord);
      drain();
      csr_valid <= 1'b1;
      csr_data <= ord;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random channel value with a bias to extremes and dark values
   function automatic logic [7:0] pick_chan();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 8));
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      req_type px;
      int burst;
      bit paused;
      logic [ORDER_W-1:0] ord_list[10];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default order, then extremes of order incl. zero and above the top
      ord_list = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd9, 4'd2, 4'd3, 4'd5, 4'd7, 4'd4};
      for (int p = 0; p < 4; p++) begin
         if (p > 0) write_order(ord_list[p]);
         send_pixel('{8'd0, 8'd0, 8'd0}, 1'b1);     // black pixel
         send_pixel('{8'd255, 8'd255, 8'd255}, 1'b1);
         send_pixel('{8'd255, 8'd0, 8'd0}, 1'b1);
         send_pixel('{8'd1, 8'd0, 8'd255}, 1'b1);
         send_pixel('{8'd0, 8'd1, 8'd0}, 1'b1);
         send_pixel('{8'd170, 8'd85, 8'd254}, 1'b0);
      end

      // random phases over listed and random orders, bursts with random gaps
      for (int p = 0; p < 10; p++) begin
         write_order(p < 4 ? ord_list[p + 6] : 4'($urandom));
         for (int n = 0; n < 75; ) begin
            burst = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
            for (int b = 0; b < burst && n < 75; b++, n++) begin
               px.red_in = pick_chan();
               px.green_in = pick_chan();
               px.blue_in = pick_chan();
               send_pixel(px, (b + 1 < burst) && (n + 1 < 75));
            end
            repeat ($urandom_range(0, 4)) @(negedge clock);
            // hold off once until everything has come back
            if (p == 5 && n >= 40 && !paused) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> pixel_power_chroma_normalize_unit.f
src/ppcn_pkg.sv
src/ppcn_power.sv
src/ppcn_divider.sv
src/pixel_power_chroma_normalize_unit.sv
dv/pixel_power_chroma_normalize_unit_checker.sv
dv/pixel_power_chroma_normalize_unit_tb.sv
